// ----- design/hld_pkg.sv -----
package hld_pkg;

	localparam int MAX_DEFECTS  = 8;
	localparam int CORDIC_STEPS = 24;

	localparam int DEF_AW = $clog2(MAX_DEFECTS);
	localparam int DEF_CW = $clog2(MAX_DEFECTS + 1);
	localparam int ENT_W  = 128;

	localparam int MUL_AW     = 48;
	localparam int MUL_BW     = 36;
	localparam int MUL_DIGITS = MUL_BW / 4;
	localparam int MUL_CW     = $clog2(MUL_DIGITS);
	localparam int MUL_PW     = MUL_AW + MUL_BW;

	localparam int COR_W  = 36;
	localparam int COR_ZW = 35;
	localparam int COR_SW = $clog2(CORDIC_STEPS);
	localparam int ANG_W  = 33;
	localparam int COS_W  = 34;

	localparam logic signed [MUL_BW-1:0] INV_TWO_PI   = 36'sd683565276;
	localparam logic signed [MUL_BW-1:0] Q_SQRT3_HALF = 36'sd929887697;
	localparam logic signed [MUL_BW-1:0] Q_HALF       = 36'sd536870912;
	localparam logic signed [MUL_BW-1:0] Q_ONE        = 36'sd1073741824;
	localparam logic signed [COR_W-1:0]  CORDIC_GAIN  = 36'sd652032874;
	localparam logic signed [COR_ZW-1:0] Z_HALF       = 35'sd2147483648;
	localparam logic signed [COR_ZW-1:0] Z_QUARTER    = 35'sd1073741824;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam logic [1:0] CFG_AMPLITUDE    = 2'd0;
	localparam logic [1:0] CFG_MEAN_DENSITY = 2'd1;
	localparam logic [1:0] CFG_DEFECT_COUNT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QP1,
		ST_QP2,
		ST_QPC,
		ST_RD,
		ST_QB1,
		ST_QB2,
		ST_QBC,
		ST_ATAN,
		ST_TERM,
		ST_COS,
		ST_SCALE,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic start;
		logic rotate;
	} cor_cmd_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [MUL_BW-1:0] wave_x(input logic [1:0] k);
		logic signed [MUL_BW-1:0] r;
		case (k)
			2'd1:    r = Q_SQRT3_HALF;
			2'd2:    r = -Q_SQRT3_HALF;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [MUL_BW-1:0] wave_y(input logic [1:0] k);
		logic signed [MUL_BW-1:0] r;
		case (k)
			2'd0:    r = Q_ONE;
			default: r = -Q_HALF;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -56'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ----- design/hld_ram.sv -----
module hld_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/hld_mul.sv -----
module hld_mul
	import hld_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [MUL_AW-1:0] a,
	input  logic signed [MUL_BW-1:0] b,
	output logic                     done,
	output logic signed [MUL_PW-1:0] prod
);

	logic signed [MUL_AW-1:0] a_q;
	logic [MUL_BW-1:0]        b_q;
	logic signed [MUL_PW-1:0] acc_q;
	logic [MUL_CW-1:0]        cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [4:0]        digit;
	logic signed [MUL_AW+4:0] pp;
	logic signed [MUL_PW-1:0] acc_next;

	// msb digit first, top digit signed
	always_comb begin
		digit = (cnt_q == '0) ? $signed({b_q[MUL_BW-1], b_q[MUL_BW-1 -: 4]})
		                      : $signed({1'b0, b_q[MUL_BW-1 -: 4]});
		pp = a_q * digit;
		acc_next = (acc_q <<< 4) + MUL_PW'(pp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CW'(MUL_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q   <= b_q << 4;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- design/hld_cordic.sv -----
module hld_cordic
	import hld_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cor_cmd_t                cmd,
	input  logic signed [ANG_W-1:0] vx,
	input  logic signed [ANG_W-1:0] vy,
	input  logic [31:0]             phase,
	output logic                    done,
	output logic signed [ANG_W-1:0] angle,
	output logic signed [COS_W-1:0] cosine
);

	logic signed [COR_W-1:0]  x_q, y_q;
	logic signed [COR_ZW-1:0] z_q;
	logic [COR_SW-1:0]        step_q;
	logic                     busy_q, done_q, rot_q, flip_q, zero_q;
	logic signed [COR_W-1:0]  xs, ys, x0, y0, negx;
	logic signed [COR_ZW-1:0] at, z0;
	logic                     sub;

	always_comb begin
		xs  = x_q >>> step_q;
		ys  = y_q >>> step_q;
		at  = $signed({3'b000, atan_turn(5'(step_q))});
		sub = rot_q ? !z_q[COR_ZW-1] : !(y_q > 0);
		x0  = COR_W'(vx);
		y0  = COR_W'(vy);
		z0  = COR_ZW'($signed(phase));
		negx = -x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == COR_SW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rot_q  <= cmd.rotate;
			zero_q <= !cmd.rotate && (vx == '0) && (vy == '0);
			flip_q <= 1'b0;
			if (cmd.rotate) begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				if (z0 > Z_QUARTER) begin
					z_q    <= z0 - Z_HALF;
					flip_q <= 1'b1;
				end else if (z0 < -Z_QUARTER) begin
					z_q    <= z0 + Z_HALF;
					flip_q <= 1'b1;
				end else begin
					z_q <= z0;
				end
			end else if (x0 < 0) begin
				if (y0 >= 0) begin
					x_q <= y0;
					y_q <= -x0;
					z_q <= Z_QUARTER;
				end else begin
					x_q <= -y0;
					y_q <= x0;
					z_q <= -Z_QUARTER;
				end
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (sub) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		if (zero_q) angle = '0;
		else if (z_q > Z_HALF) angle = ANG_W'(Z_HALF);
		else if (z_q < -Z_HALF) angle = ANG_W'(-Z_HALF);
		else angle = ANG_W'(z_q);
		cosine = flip_q ? COS_W'(negx) : COS_W'(x_q);
	end

	assign done = done_q;

endmodule

// ----- design/hex_lattice_dislocation_field.sv -----
// throughput: one item at a time; the shared 9-step multiplier and the shared
// cordic unit (CORDIC_STEPS iterations) are used in turn for every term
// a finished result waits in the output register while the next item is taken
// reset: asynchronous, active low; clears control and configuration, table stays unwritten
module hex_lattice_dislocation_field
	import hld_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [2:0]         entry_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] burgers_in_x,
	input  logic signed [31:0] burgers_in_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] density_value,
	output logic signed [31:0] negative_term,
	output logic signed [31:0] positive_term,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	st_t                      state_q, state_d;
	logic                     launched_q;
	logic [1:0]               k_q;
	logic [DEF_CW-1:0]        j_q, n_q;
	logic signed [31:0]       amp_q, mean_q;
	logic [3:0]               dcount_q;
	logic signed [31:0]       px_q, py_q;
	logic signed [63:0]       dot_q;
	logic signed [MUL_AW-1:0] s_q;
	logic [31:0]              phase_q;
	logic signed [COS_W-1:0]  sum_q;
	logic signed [53:0]       scaled_q;
	logic                     out_valid_q;
	logic signed [31:0]       dv_q, neg_q, pos_q;

	logic                     in_acc, ram_we, out_free;
	logic [ENT_W-1:0]         ram_rdata;
	logic signed [31:0]       ent_px, ent_py, ent_bx, ent_by;
	logic                     mul_start, mul_done;
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] mul_p;
	cor_cmd_t                 cor_cmd;
	logic                     cor_done;
	logic signed [ANG_W-1:0]  cor_angle;
	logic signed [COS_W-1:0]  cor_cos;
	logic signed [ANG_W-1:0]  dx, dy;
	logic                     is_mul, is_cor, step_done;
	logic signed [55:0]       dv_w, neg_w;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign ram_we   = in_acc && (mode == MODE_LOAD) && (entry_index < MAX_DEFECTS);

	hld_ram #(.WIDTH(ENT_W), .DEPTH(MAX_DEFECTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (DEF_AW'(entry_index)),
		.wdata ({coord_x, coord_y, burgers_in_x, burgers_in_y}),
		.raddr (j_q[DEF_AW-1:0]),
		.rdata (ram_rdata)
	);

	assign {ent_px, ent_py, ent_bx, ent_by} = ram_rdata;

	hld_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	assign dx = ANG_W'(px_q) - ANG_W'(ent_px);
	assign dy = ANG_W'(py_q) - ANG_W'(ent_py);

	hld_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cor_cmd),
		.vx     (dx),
		.vy     (dy),
		.phase  (phase_q),
		.done   (cor_done),
		.angle  (cor_angle),
		.cosine (cor_cos)
	);

	// sequencer outputs
	always_comb begin
		is_mul = 1'b0;
		is_cor = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_QP1: begin
				is_mul = 1'b1;
				mul_a  = MUL_AW'(px_q);
				mul_b  = wave_x(k_q);
			end
			ST_QP2: begin
				is_mul = 1'b1;
				mul_a  = MUL_AW'(py_q);
				mul_b  = wave_y(k_q);
			end
			ST_QB1: begin
				is_mul = 1'b1;
				mul_a  = MUL_AW'(ent_bx);
				mul_b  = wave_x(k_q);
			end
			ST_QB2: begin
				is_mul = 1'b1;
				mul_a  = MUL_AW'(ent_by);
				mul_b  = wave_y(k_q);
			end
			ST_QPC, ST_QBC: begin
				is_mul = 1'b1;
				mul_a  = dot_q[63:16];
				mul_b  = INV_TWO_PI;
			end
			ST_TERM: begin
				is_mul = 1'b1;
				mul_a  = s_q;
				mul_b  = MUL_BW'(cor_angle);
			end
			ST_SCALE: begin
				is_mul = 1'b1;
				mul_a  = MUL_AW'(sum_q);
				mul_b  = MUL_BW'(amp_q);
			end
			ST_ATAN, ST_COS: is_cor = 1'b1;
			default: ;
		endcase
		mul_start      = is_mul && !launched_q;
		cor_cmd.start  = is_cor && !launched_q;
		cor_cmd.rotate = (state_q == ST_COS);
		step_done      = (is_mul && mul_done) || (is_cor && cor_done);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && mode == MODE_EVAL) state_d = ST_QP1;
			ST_QP1:   if (mul_done) state_d = ST_QP2;
			ST_QP2:   if (mul_done) state_d = ST_QPC;
			ST_QPC:   if (mul_done) state_d = (n_q == '0) ? ST_COS : ST_RD;
			ST_RD:    state_d = ST_QB1;
			ST_QB1:   if (mul_done) state_d = ST_QB2;
			ST_QB2:   if (mul_done) state_d = ST_QBC;
			ST_QBC:   if (mul_done) state_d = ST_ATAN;
			ST_ATAN:  if (cor_done) state_d = ST_TERM;
			ST_TERM: begin
				if (mul_done) state_d = (DEF_CW'(j_q + 1'b1) == n_q) ? ST_COS : ST_RD;
			end
			ST_COS:   if (cor_done) state_d = (k_q == 2'd2) ? ST_SCALE : ST_QP1;
			ST_SCALE: if (mul_done) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dv_w  = 56'(mean_q) + 56'(scaled_q);
		neg_w = -56'(scaled_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			k_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			amp_q       <= '0;
			mean_q      <= '0;
			dcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (step_done) launched_q <= 1'b0;
			else if (mul_start || cor_cmd.start) launched_q <= 1'b1;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_AMPLITUDE:    amp_q    <= cfg_data;
					CFG_MEAN_DENSITY: mean_q   <= cfg_data;
					CFG_DEFECT_COUNT: dcount_q <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (state_q == ST_IDLE && in_acc) begin
				k_q <= '0;
				n_q <= (dcount_q > MAX_DEFECTS) ? DEF_CW'(MAX_DEFECTS) : DEF_CW'(dcount_q);
			end
			if (state_q == ST_QPC && mul_done) j_q <= '0;
			if (state_q == ST_TERM && mul_done) j_q <= DEF_CW'(j_q + 1'b1);
			if (state_q == ST_COS && cor_done) k_q <= k_q + 1'b1;

			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			px_q  <= coord_x;
			py_q  <= coord_y;
			sum_q <= '0;
		end
		if (mul_done) begin
			case (state_q)
				ST_QP1, ST_QB1: dot_q <= mul_p[63:0];
				ST_QP2, ST_QB2: dot_q <= dot_q + mul_p[63:0];
				ST_QPC:         phase_q <= mul_p[61:30];
				ST_QBC:         s_q <= mul_p[77:30];
				ST_TERM:        phase_q <= phase_q - mul_p[63:32];
				ST_SCALE:       scaled_q <= mul_p[83:30];
				default: ;
			endcase
		end
		if (state_q == ST_COS && cor_done) sum_q <= sum_q + cor_cos;
		if (state_q == ST_OUT && out_free) begin
			dv_q  <= sat32(dv_w);
			neg_q <= sat32(neg_w);
			pos_q <= sat32(56'(scaled_q));
		end
	end

	assign out_valid     = out_valid_q;
	assign density_value = dv_q;
	assign negative_term = neg_q;
	assign positive_term = pos_q;

endmodule

// ----- design/hld_chk.sv -----
module hld_chk
	import hld_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               mode,
	input logic [2:0]         entry_index,
	input logic signed [31:0] coord_x,
	input logic signed [31:0] coord_y,
	input logic signed [31:0] burgers_in_x,
	input logic signed [31:0] burgers_in_y,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] density_value,
	input logic signed [31:0] negative_term,
	input logic signed [31:0] positive_term,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [1:0]         cfg_index,
	input logic [31:0]        cfg_data
);

	// an evaluate item holds off the next one
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_EVAL) |=> in_stall)
		else $error("evaluate item did not hold off input");

	// a load item never raises a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_LOAD && !out_valid) |=> !out_valid)
		else $error("load item produced a result");

	// the two amplitude terms mirror each other
	a_terms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (negative_term == -positive_term) || (negative_term == ~positive_term))
		else $error("negative and positive terms disagree");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(density_value))
		else $error("stalled item changed");

endmodule

bind hex_lattice_dislocation_field hld_chk u_hld_chk (.*);

// ----- dv/tb.sv -----
module tb;
	import hld_pkg::*;

	typedef struct packed {
		logic signed [31:0] dens;
		logic signed [31:0] neg;
		logic signed [31:0] pos;
	} field_t;

	typedef struct {
		bit                 is_cfg;
		logic [1:0]         reg_idx;
		logic [31:0]        reg_val;
		logic               m;
		logic [2:0]         slot;
		logic signed [31:0] x, y, bx, by;
		bit                 typed;
		field_t             e;
	} stim_row_t;

	localparam longint TURN_ATAN [32] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
		64'h00000001, 64'h00000000
	};
	localparam longint K_S    = 929887697;
	localparam longint K_ONE  = 1073741824;
	localparam longint K_HALF = 536870912;
	localparam longint K_INV  = 683565276;
	localparam longint K_GAIN = 652032874;
	localparam longint K_HT   = 64'sd2147483648;
	localparam longint K_QT   = 1073741824;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               mode = 0;
	logic [2:0]         entry_index = 0;
	logic signed [31:0] coord_x = 0, coord_y = 0, burgers_in_x = 0, burgers_in_y = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] density_value, negative_term, positive_term;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = 0;
	logic [31:0]        cfg_data = 0;

	longint     lat_amp, lat_mean;
	int         lat_count;
	longint     dis_px [8], dis_py [8], dis_bx [8], dis_by [8];
	field_t     pending_fields [$];
	stim_row_t  rows [$];
	int         mismatches = 0;
	int         send_idle_pct = 0, recv_idle_pct = 0;

	hex_lattice_dislocation_field DUT (.*);

	always #6 clk = ~clk;

	always @(negedge clk) out_stall = ($urandom_range(99) < recv_idle_pct);

	function automatic longint atan_turns(longint y, longint x);
		longint z = 0, t, xs, ys;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = K_QT;
			end else begin
				t = x; x = -y; y = t; z = -K_QT;
			end
		end
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += TURN_ATAN[i];
			end else begin
				x -= ys; y += xs; z -= TURN_ATAN[i];
			end
		end
		if (z > K_HT) z = K_HT;
		if (z < -K_HT) z = -K_HT;
		return z;
	endfunction

	function automatic longint cos_turns(logic [31:0] ph);
		longint z = longint'($signed(ph));
		longint x = K_GAIN, y = 0, xs, ys;
		bit flip = 0;
		if (z > K_QT) begin
			z -= K_HT; flip = 1;
		end else if (z < -K_QT) begin
			z += K_HT; flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= TURN_ATAN[i];
			end else begin
				x += ys; y -= xs; z += TURN_ATAN[i];
			end
		end
		return flip ? -x : x;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic field_t lattice_field(longint px, longint py);
		longint wx [3] = '{0, K_S, -K_S};
		longint wy [3] = '{K_ONE, -K_HALF, -K_HALF};
		longint sum = 0, qp, qb, hi, lo, s, t, scaled;
		logic [63:0] prod;
		logic [31:0] ph;
		int n = lat_count > MAX_DEFECTS ? MAX_DEFECTS : lat_count;
		field_t r;
		for (int k = 0; k < 3; k++) begin
			qp = (wx[k] * px + wy[k] * py) >>> 16;
			prod = qp * K_INV;
			ph = prod[61:30];
			for (int j = 0; j < n; j++) begin
				qb = (wx[k] * dis_bx[j] + wy[k] * dis_by[j]) >>> 16;
				hi = qb >>> 30;
				lo = qb - hi * K_ONE;
				s = hi * K_INV + ((lo * K_INV) >>> 30);
				t = atan_turns(py - dis_py[j], px - dis_px[j]);
				prod = s * t;
				ph = ph - prod[63:32];
			end
			sum += cos_turns(ph);
		end
		scaled = (lat_amp * sum) >>> 30;
		r.dens = clip32(lat_mean + scaled);
		r.neg  = clip32(-scaled);
		r.pos  = clip32(scaled);
		return r;
	endfunction

	task automatic report(string what, field_t e, field_t a);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %h %h %h got %h %h %h", what,
				e.dens, e.neg, e.pos, a.dens, a.neg, a.pos);
	endtask

	always @(posedge clk) begin
		field_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{density_value, negative_term, positive_term};
			if (pending_fields.size() == 0) begin
				report("unexpected result", '0, got);
			end else begin
				want = pending_fields.pop_front();
				if (got.dens !== want.dens || got.neg !== want.neg || got.pos !== want.pos)
					report("field mismatch", want, got);
			end
		end
	end

	task automatic wait_idle();
		while (pending_fields.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_AMPLITUDE:    lat_amp = longint'($signed(val));
			CFG_MEAN_DENSITY: lat_mean = longint'($signed(val));
			CFG_DEFECT_COUNT: lat_count = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_item(stim_row_t r);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_valid = 1;
		mode = r.m;
		entry_index = r.slot;
		coord_x = r.x;
		coord_y = r.y;
		burgers_in_x = r.bx;
		burgers_in_y = r.by;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (r.m == MODE_LOAD) begin
			dis_px[r.slot] = r.x;
			dis_py[r.slot] = r.y;
			dis_bx[r.slot] = r.bx;
			dis_by[r.slot] = r.by;
		end else begin
			pending_fields.push_back(r.typed ? r.e : lattice_field(r.x, r.y));
		end
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic void add_cfg(logic [1:0] idx, logic [31:0] val);
		stim_row_t r = '{default: '0};
		r.is_cfg = 1;
		r.reg_idx = idx;
		r.reg_val = val;
		rows.push_back(r);
	endfunction

	function automatic void add_item(logic m, logic [2:0] slot, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] bx, logic signed [31:0] by,
			bit typed, field_t e);
		stim_row_t r = '{default: '0};
		r.m = m; r.slot = slot; r.x = x; r.y = y; r.bx = bx; r.by = by;
		r.typed = typed; r.e = e;
		rows.push_back(r);
	endfunction

	function automatic logic signed [31:0] near_coord();
		return $signed($urandom_range(0, 1048575)) - 524288;
	endfunction

	function automatic logic signed [31:0] any_coord();
		return ($urandom_range(1)) ? $signed($urandom) : near_coord();
	endfunction

	function automatic logic [31:0] any_level();
		case ($urandom_range(7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 67108864)) - 33554432;
		endcase
	endfunction

	localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] SMIN = 32'sh80000000;

	initial begin
		stim_row_t r;
		lat_amp = 0; lat_mean = 0; lat_count = 0;

		// after reset: zero amplitude gives zero everywhere
		add_item(MODE_EVAL, 0, 0, 0, 0, 0, 1, '0);
		add_item(MODE_EVAL, 0, SMAX, SMIN, 0, 0, 1, '0);
		add_item(MODE_EVAL, 0, SMIN, SMAX, 0, 0, 1, '0);
		add_item(MODE_LOAD, 0, 0, 0, 32'sd65536, 0, 0, '0);
		add_item(MODE_LOAD, 1, 32'sd131072, 0, 32'sd32768, 32'sd56756, 0, '0);
		add_item(MODE_LOAD, 2, SMAX, SMAX, SMIN, SMIN, 0, '0);
		add_item(MODE_LOAD, 3, SMIN, SMIN, SMAX, SMAX, 0, '0);
		for (int i = 4; i < 8; i++)
			add_item(MODE_LOAD, 3'(i), near_coord(), near_coord(), near_coord(), near_coord(),
				0, '0);
		add_cfg(CFG_AMPLITUDE, 32'h01000000);
		add_cfg(CFG_MEAN_DENSITY, 32'h00800000);
		add_cfg(CFG_DEFECT_COUNT, 2);
		// point on a dislocation, then on its negative x axis
		add_item(MODE_EVAL, 0, 0, 0, 0, 0, 0, '0);
		add_item(MODE_EVAL, 0, -32'sd196608, 32'sd131072 - 32'sd131072, 0, 0, 0, '0);
		add_item(MODE_EVAL, 0, 32'sd65536, 32'sd65536, 0, 0, 0, '0);
		add_item(MODE_EVAL, 0, SMAX, SMAX, 0, 0, 0, '0);
		add_item(MODE_EVAL, 0, SMIN, SMIN, 0, 0, 0, '0);
		// count above capacity
		add_cfg(CFG_DEFECT_COUNT, 15);
		add_item(MODE_EVAL, 0, 32'sd32768, 32'sd16384, 0, 0, 0, '0);
		// saturation both ways
		add_cfg(CFG_DEFECT_COUNT, 0);
		add_cfg(CFG_AMPLITUDE, 32'h7FFFFFFF);
		add_cfg(CFG_MEAN_DENSITY, 32'h7FFFFFFF);
		add_item(MODE_EVAL, 0, 0, 0, 0, 0, 1, '{SMAX, SMIN, SMAX});
		add_cfg(CFG_AMPLITUDE, 32'h80000000);
		add_cfg(CFG_MEAN_DENSITY, 32'h80000000);
		add_item(MODE_EVAL, 0, 0, 0, 0, 0, 1, '{SMIN, SMAX, SMIN});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_idle();
				write_reg(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				send_item(rows[i]);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 68 : 0;
			recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 27 : 0;
			for (int seg = 0; seg < 4; seg++) begin
				wait_idle();
				write_reg(CFG_AMPLITUDE, any_level());
				write_reg(CFG_MEAN_DENSITY, any_level());
				write_reg(CFG_DEFECT_COUNT,
					($urandom_range(7) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 3));
				for (int i = 0; i < 32; i++) begin
					r = '{default: '0};
					r.m = ($urandom_range(9) < 3) ? MODE_LOAD : MODE_EVAL;
					r.slot = $urandom_range(7);
					r.x = any_coord();
					r.y = any_coord();
					r.bx = ($urandom_range(3) == 0) ? $signed($urandom) : near_coord();
					r.by = ($urandom_range(3) == 0) ? $signed($urandom) : near_coord();
					send_item(r);
				end
			end
		end

		while (pending_fields.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#60000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
